// ===== rtl/sha256c_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 compression: shared package
// Word and control types, sequencer states, round constants and the
// sigma functions of the SHA-256 round and message schedule.
// ----------------------------------------------------------------------------
package sha256c_pkg;

	// Fixed word geometry of SHA-256.
	localparam int WORD_W      = 32;
	localparam int CHAIN_WORDS = 8;
	localparam int BLOCK_WORDS = 16;
	localparam int CIDX_W      = $clog2(CHAIN_WORDS);
	localparam int MIDX_W      = $clog2(BLOCK_WORDS);
	localparam int KIDX_W      = 6;
	localparam int ROUNDS_DEF  = 64;

	// Message schedule taps relative to the current word.
	localparam int TAP_S0 = 1;
	localparam int TAP_W9 = 9;
	localparam int TAP_S1 = 14;

	typedef logic [WORD_W-1:0] word_t;

	// Control from the sequencer to the message schedule.
	typedef struct packed {
		logic load;
		logic step;
	} sched_ctrl_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PREP,
		ST_ROUND,
		ST_FINAL,
		ST_OUT
	} state_t;

	localparam word_t ROUND_K [1 << KIDX_W] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	function automatic word_t rotr(input word_t x, input int n);
		return (x >> n) | (x << (WORD_W - n));
	endfunction

	function automatic word_t big_sigma0(input word_t x);
		return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
	endfunction

	function automatic word_t big_sigma1(input word_t x);
		return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
	endfunction

	function automatic word_t small_sigma0(input word_t x);
		return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
	endfunction

	function automatic word_t small_sigma1(input word_t x);
		return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
	endfunction

endpackage

// ===== rtl/sha256c_sched.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 compression: message schedule
// Sixteen-word shift line. Message words shift in at the tail while a block
// is gathered; during the rounds each step shifts in the next expanded word.
// ----------------------------------------------------------------------------
module sha256c_sched (
	input  logic                      clk,
	input  sha256c_pkg::sched_ctrl_t  ctrl,
	input  sha256c_pkg::word_t        load_word,
	output sha256c_pkg::word_t        w_cur,
	output sha256c_pkg::word_t        w_next
);
	import sha256c_pkg::*;

	word_t w_q [BLOCK_WORDS];
	word_t exp_word;
	word_t shift_in;

	// Next schedule word from the fixed taps of the line.
	always_comb begin
		exp_word = w_q[0] + small_sigma0(w_q[TAP_S0]) + w_q[TAP_W9]
			+ small_sigma1(w_q[TAP_S1]);
		shift_in = ctrl.load ? load_word : exp_word;
	end

	// The line moves one place on a load or a round step.
	always_ff @(posedge clk) begin
		if (ctrl.load || ctrl.step) begin
			for (int i = 0; i < BLOCK_WORDS - 1; i++) begin
				w_q[i] <= w_q[i + 1];
			end
			w_q[BLOCK_WORDS - 1] <= shift_in;
		end
	end

	assign w_cur  = w_q[0];
	assign w_next = w_q[1];

endmodule

// ===== rtl/sha256_compression.sv =====
`timescale 1ns / 1ps
// Chaining and message items are taken only while idle. The sixteenth message
// word starts a compression: a setup state, one round per cycle on the shared
// round adder, then the chaining add, followed by eight digest items, one per
// cycle when the output is not stalled.
// Input stall stays high from the sixteenth word until the last digest item.
// Reset clears the sequencer and counters; chaining words hold no reset value.
// ----------------------------------------------------------------------------
// SHA-256 compression: top level
// Gathers chaining and message words, runs the rounds under a small
// sequencer and delivers the updated chaining value word by word.
// ----------------------------------------------------------------------------
module sha256_compression #(
	parameter int ROUNDS = sha256c_pkg::ROUNDS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic                       cmd,
	input  sha256c_pkg::word_t         data_word,
	output logic                       out_valid,
	input  logic                       out_stall,
	output sha256c_pkg::word_t         digest_word,
	output logic [sha256c_pkg::CIDX_W-1:0] word_index,
	output logic                       last_word
);
	import sha256c_pkg::*;

	localparam int RW = $clog2(ROUNDS);
	localparam logic [RW-1:0]     LAST_ROUND = RW'(ROUNDS - 1);
	localparam logic [MIDX_W-1:0] LAST_MSG   = MIDX_W'(BLOCK_WORDS - 1);
	localparam logic [CIDX_W-1:0] LAST_IDX   = CIDX_W'(CHAIN_WORDS - 1);

	state_t              state_q, state_d;
	logic [MIDX_W-1:0]   msg_cnt_q;
	logic [CIDX_W-1:0]   load_idx_q;
	logic [CIDX_W-1:0]   out_idx_q;
	logic [RW-1:0]       round_q;
	word_t               chain_q [CHAIN_WORDS];
	word_t               v_q [CHAIN_WORDS];
	word_t               kw_q;
	logic                in_acc;
	logic                out_acc;
	sched_ctrl_t         sched_ctrl;
	word_t               w_cur, w_next;
	logic [KIDX_W-1:0]   k_next_idx;
	word_t               t1, t2;

	sha256c_sched u_sched (
		.clk       (clk),
		.ctrl      (sched_ctrl),
		.load_word (data_word),
		.w_cur     (w_cur),
		.w_next    (w_next)
	);

	assign in_acc  = in_valid && !in_stall;
	assign out_acc = out_valid && !out_stall;

	// Sequencer: next state and handshake outputs.
	always_comb begin
		state_d         = state_q;
		in_stall        = 1'b1;
		out_valid       = 1'b0;
		sched_ctrl.load = 1'b0;
		sched_ctrl.step = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_stall        = 1'b0;
				sched_ctrl.load = in_valid && !cmd;
				if (in_valid && !cmd && msg_cnt_q == LAST_MSG) begin
					state_d = ST_PREP;
				end
			end
			ST_PREP: begin
				state_d = ST_ROUND;
			end
			ST_ROUND: begin
				sched_ctrl.step = 1'b1;
				if (round_q == LAST_ROUND) begin
					state_d = ST_FINAL;
				end
			end
			ST_FINAL: begin
				state_d = ST_OUT;
			end
			ST_OUT: begin
				out_valid = 1'b1;
				if (!out_stall && out_idx_q == LAST_IDX) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Counters for message words, chaining loads, rounds and output words.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			msg_cnt_q  <= '0;
			load_idx_q <= '0;
			out_idx_q  <= '0;
			round_q    <= '0;
		end else begin
			if (in_acc && !cmd) begin
				msg_cnt_q <= msg_cnt_q + 1'b1;
			end
			if (in_acc && cmd) begin
				load_idx_q <= load_idx_q + 1'b1;
			end
			if (state_q == ST_PREP) begin
				round_q <= '0;
			end else if (state_q == ST_ROUND) begin
				round_q <= round_q + 1'b1;
			end
			if (state_q == ST_FINAL) begin
				out_idx_q <= '0;
			end else if (out_acc) begin
				out_idx_q <= out_idx_q + 1'b1;
			end
		end
	end

	// Round function on the working variables a..h.
	always_comb begin
		t1 = v_q[7] + big_sigma1(v_q[4]) + (v_q[6] ^ (v_q[4] & (v_q[5] ^ v_q[6])))
			+ kw_q;
		t2 = big_sigma0(v_q[0]) + ((v_q[0] & v_q[1]) | (v_q[2] & (v_q[0] | v_q[1])));
		k_next_idx = round_q[KIDX_W-1:0] + 1'b1;
	end

	// Chaining value, working variables and the constant-plus-word register.
	always_ff @(posedge clk) begin
		if (in_acc && cmd) begin
			chain_q[load_idx_q] <= data_word;
		end
		unique case (state_q)
			ST_PREP: begin
				for (int i = 0; i < CHAIN_WORDS; i++) begin
					v_q[i] <= chain_q[i];
				end
				kw_q <= ROUND_K[0] + w_cur;
			end
			ST_ROUND: begin
				v_q[7] <= v_q[6];
				v_q[6] <= v_q[5];
				v_q[5] <= v_q[4];
				v_q[4] <= v_q[3] + t1;
				v_q[3] <= v_q[2];
				v_q[2] <= v_q[1];
				v_q[1] <= v_q[0];
				v_q[0] <= t1 + t2;
				kw_q   <= ROUND_K[k_next_idx] + w_next;
			end
			ST_FINAL: begin
				for (int i = 0; i < CHAIN_WORDS; i++) begin
					chain_q[i] <= chain_q[i] + v_q[i];
				end
			end
			default: begin
			end
		endcase
	end

	// Output item taken straight from the updated chaining value.
	assign digest_word = chain_q[out_idx_q];
	assign word_index  = out_idx_q;
	assign last_word   = (out_idx_q == LAST_IDX);

endmodule
